// ===== sv/fvn_pkg.sv =====
// fvn_pkg: shared types and constants of the fractal value noise block.
// No dependencies; every other file refers to it by scoped names.
package fvn_pkg;

   localparam int COORD_W = 24;   // signed Q16.8 point coordinate
   localparam int IDX_W   = 8;    // table slot field
   localparam int VAL_W   = 8;    // table value field
   localparam int NOISE_W = 16;   // Q0.16 result
   localparam int FREQ_W  = 16;
   localparam int OCT_W   = 4;
   localparam int CSR_W   = 16;   // widest register
   localparam int CSR_IDX_W = 1;
   localparam int FRAC_W  = 16;   // Q0.16 fraction fed to smoothstep
   localparam int WGT_W   = 17;   // smoothstep weight, up to 1.0

   localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd256;
   localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd1;
   localparam logic [17:0]       SMOOTH_THREE = 18'h30000;   // 3.0 in Q2.16

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FREQUENCY = 1'b0,
      CSR_OCTAVES   = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_EVAL = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW,
      ST_COL0,
      ST_COL1,
      ST_MIX0,
      ST_MIX1,
      ST_MIX2,
      ST_ACC,
      ST_DSTART,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ===== sv/fvn_chan_if.sv =====
// Request and response channel interfaces of the fractal value noise block.
// Depends on fvn_pkg for field widths.
interface fvn_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [fvn_pkg::COORD_W-1:0]  x_coord;
   logic [fvn_pkg::COORD_W-1:0]  y_coord;
   logic [fvn_pkg::IDX_W-1:0]    entry_index;
   logic [fvn_pkg::VAL_W-1:0]    entry_value;

   modport source (output valid, kind, x_coord, y_coord, entry_index, entry_value,
                   input ready);
   modport sink   (input valid, kind, x_coord, y_coord, entry_index, entry_value,
                   output ready);
endinterface

interface fvn_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fvn_pkg::NOISE_W-1:0]  noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

// ===== sv/fvn_perm_ram.sv =====
// fvn_perm_ram: permutation table, one write port and two registered read ports.
// Depends on fvn_pkg for the entry width.
module fvn_perm_ram #(
   parameter int TABLE_SIZE = 256,
   parameter int ADDR_W = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [fvn_pkg::VAL_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]           rd_a_addr,
   input  logic [ADDR_W-1:0]           rd_b_addr,
   output logic [fvn_pkg::VAL_W-1:0]   rd_a_data,
   output logic [fvn_pkg::VAL_W-1:0]   rd_b_data
);

   logic [fvn_pkg::VAL_W-1:0] mem [TABLE_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// ===== sv/fvn_smooth.sv =====
// fvn_smooth: two-stage smoothstep weight, w = t*t*(3 - 2t), Q0.16 in, Q1.16 out.
// Free running, registered in t2_ff/m_ff, then weight_ff. Depends on fvn_pkg.
module fvn_smooth (
   input  logic                        clock,
   input  logic [fvn_pkg::FRAC_W-1:0]  frac,
   output logic [fvn_pkg::WGT_W-1:0]   weight
);

   logic [31:0] sq;
   logic [15:0] t2_ff;
   logic [17:0] m_ff;
   logic [33:0] wp;
   logic [fvn_pkg::WGT_W-1:0] weight_ff;

   assign sq = frac * frac;
   assign wp = t2_ff * m_ff;

   always_ff @(posedge clock) begin
      t2_ff     <= sq[31:16];
      m_ff      <= fvn_pkg::SMOOTH_THREE - {1'b0, frac, 1'b0};
      weight_ff <= wp[32:16];
   end

   assign weight = weight_ff;

endmodule

// ===== sv/fvn_div.sv =====
// fvn_div: restoring divider, one quotient bit per cycle, NOISE_W-bit quotient.
// The caller guarantees the quotient fits. Depends on fvn_pkg.
module fvn_div #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIVIDEND_W-1:0]        dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   output logic                         done,
   output logic [fvn_pkg::NOISE_W-1:0]  quotient
);

   localparam int QW = fvn_pkg::NOISE_W;
   localparam int CW = $clog2(QW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dsh_ff, dsh_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic              fits;

   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dsh_in  = DIVIDEND_W'(divisor) << (QW - 1);
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[QW-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/fractal_value_noise_2d.sv =====
// fractal_value_noise_2d: top level, octave sequencer around the permutation table.
// Depends on fvn_pkg, fvn_chan_if, fvn_perm_ram, fvn_smooth and fvn_div.
//
//   channel  direction  handshake        payload
//   req_ch   in         valid/ready      kind, x_coord, y_coord, entry_index, entry_value
//   rsp_ch   out        valid/ready      noise_value
//   csr_*    in         csr_we only      csr_index, csr_wdata
//
// A load item writes the table at acceptance.
// An evaluate item runs the states ROW, COL0, COL1, MIX0, MIX1, MIX2 and ACC once
// per clamped octave, paced by the three dependent table reads through the
// registered read ports and the three blend multiplies; then DSTART starts the divide,
// DIV waits for its done flag and OUT loads the output register. The sequencer then
// returns to idle, and only there is the next item taken.
// Reset (synchronous) restores frequency 256 and one octave; table is not cleared.
// The result waits in an output register; a new item is taken while it waits.
// A stalled response only holds the sequencer if a second result is ready.
// TABLE_SIZE must be a power of two: all table indexing wraps by masking.
module fractal_value_noise_2d #(
   parameter int TABLE_SIZE      = 256,
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   fvn_req_if.sink                        req_ch,
   fvn_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [fvn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fvn_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int TW  = $clog2(TABLE_SIZE);
   localparam int PF  = COORD_FRAC_BITS + 8;       // fraction bits of scaled coords
   localparam int WW  = PF + TW;                   // only lattice mod T and fraction kept
   localparam int KW  = $clog2(MAX_OCTAVES + 1);
   localparam int AW  = 24 + MAX_OCTAVES;          // weighted octave sum
   localparam int DW  = AW - 8;                    // sum / 256
   localparam int PW  = fvn_pkg::COORD_W + fvn_pkg::FREQ_W + 1;

   // configuration
   logic [fvn_pkg::FREQ_W-1:0] freq_ff;
   logic [fvn_pkg::OCT_W-1:0]  oct_ff;

   // sequencer
   fvn_pkg::state_type state_ff, state_in;
   logic [KW-1:0] oct_cnt_ff, oct_cnt_in;
   logic [KW-1:0] oct_idx_ff, oct_idx_in;
   logic          req_ready;
   logic          req_fire;
   logic          tbl_we;
   logic          div_start;
   logic          out_load;

   // datapath
   logic [WW-1:0] xw_ff, xw_in, yw_ff, yw_in;
   logic [fvn_pkg::VAL_W-1:0] p1_ff, p1_in;
   logic [fvn_pkg::VAL_W-1:0] c00_ff, c00_in, c01_ff, c01_in;
   logic signed [26:0] lo_prod_ff, lo_prod_in, hi_prod_ff, hi_prod_in;
   logic [23:0] low_ff, low_in, high_ff, high_in;
   logic signed [42:0] fin_prod_ff, fin_prod_in;
   logic [AW-1:0] acc_ff, acc_in;

   logic signed [PW-1:0] x_prod, y_prod;
   logic [TW-1:0] x0, x1, y0, y1;
   logic [TW-1:0] ra_addr, rb_addr, row_base;
   logic [fvn_pkg::VAL_W-1:0] ra_data, rb_data;
   logic [PF+15:0] x_fx, y_fx;
   logic [fvn_pkg::FRAC_W-1:0] x_frac, y_frac;
   logic [fvn_pkg::WGT_W-1:0] wx, wy;
   logic signed [8:0]  d_corner;
   logic signed [26:0] blend_sum;
   logic signed [24:0] d_row;
   logic signed [25:0] n_sum;
   logic [MAX_OCTAVES:0] dvs_wide;
   logic [MAX_OCTAVES-1:0] divisor;
   logic div_done;
   logic [fvn_pkg::NOISE_W-1:0] quotient;
   logic [fvn_pkg::NOISE_W-1:0] rsp_data_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0] oct_clamp;
   logic in_range;

   assign req_fire = req_ch.valid && req_ready;
   assign in_range = int'(req_ch.entry_index) < TABLE_SIZE;
   assign tbl_we   = req_fire && (req_ch.kind == fvn_pkg::KIND_LOAD) && in_range;

   // configuration registers, to be written only while idle; the user must ensure it, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= fvn_pkg::FREQ_RESET;
         oct_ff  <= fvn_pkg::OCT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fvn_pkg::CSR_FREQUENCY: freq_ff <= csr_wdata[fvn_pkg::FREQ_W-1:0];
            fvn_pkg::CSR_OCTAVES:   oct_ff  <= csr_wdata[fvn_pkg::OCT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero octaves act as one, excess saturates
   always_comb begin
      if (oct_ff == '0) begin
         oct_clamp = KW'(1);
      end else if (int'(oct_ff) > MAX_OCTAVES) begin
         oct_clamp = KW'(MAX_OCTAVES);
      end else begin
         oct_clamp = KW'(oct_ff);
      end
   end

   // lattice coordinates and fractions of the current octave
   assign x0 = xw_ff[WW-1:PF];
   assign y0 = yw_ff[WW-1:PF];
   assign x1 = x0 + 1'b1;
   assign y1 = y0 + 1'b1;
   assign x_fx = ((PF + 16)'(xw_ff[PF-1:0]) << 16) >> PF;
   assign y_fx = ((PF + 16)'(yw_ff[PF-1:0]) << 16) >> PF;
   assign x_frac = x_fx[15:0];
   assign y_frac = y_fx[15:0];

   assign x_prod = $signed(req_ch.x_coord) * $signed({1'b0, freq_ff});
   assign y_prod = $signed(req_ch.y_coord) * $signed({1'b0, freq_ff});

   // table read addresses: rows first, then the two corner pairs
   always_comb begin
      row_base = TW'(ra_data);
      case (state_ff)
         fvn_pkg::ST_COL0: begin
            ra_addr = row_base + x0;
            rb_addr = row_base + x1;
         end
         fvn_pkg::ST_COL1: begin
            ra_addr = TW'(p1_ff) + x0;
            rb_addr = TW'(p1_ff) + x1;
         end
         default: begin
            ra_addr = y0;
            rb_addr = y1;
         end
      endcase
   end

   fvn_perm_ram #(
      .TABLE_SIZE (TABLE_SIZE),
      .ADDR_W     (TW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (TW'(req_ch.entry_index)),
      .wr_data   (req_ch.entry_value),
      .rd_a_addr (ra_addr),
      .rd_b_addr (rb_addr),
      .rd_a_data (ra_data),
      .rd_b_data (rb_data)
   );

   fvn_smooth u_smooth_x (.clock(clock), .frac(x_frac), .weight(wx));
   fvn_smooth u_smooth_y (.clock(clock), .frac(y_frac), .weight(wy));

   assign dvs_wide = ({{MAX_OCTAVES{1'b0}}, 1'b1} << oct_cnt_ff) - 1'b1;
   assign divisor  = dvs_wide[MAX_OCTAVES-1:0];

   fvn_div #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (MAX_OCTAVES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff[AW-1:8]),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // sequencer: next state and control
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         fvn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid && req_ch.kind == fvn_pkg::KIND_EVAL) begin
               state_in = fvn_pkg::ST_ROW;
            end
         end
         fvn_pkg::ST_ROW:  state_in = fvn_pkg::ST_COL0;
         fvn_pkg::ST_COL0: state_in = fvn_pkg::ST_COL1;
         fvn_pkg::ST_COL1: state_in = fvn_pkg::ST_MIX0;
         fvn_pkg::ST_MIX0: state_in = fvn_pkg::ST_MIX1;
         fvn_pkg::ST_MIX1: state_in = fvn_pkg::ST_MIX2;
         fvn_pkg::ST_MIX2: state_in = fvn_pkg::ST_ACC;
         fvn_pkg::ST_ACC: begin
            if (oct_idx_ff == oct_cnt_ff - 1'b1) begin
               state_in = fvn_pkg::ST_DSTART;
            end else begin
               state_in = fvn_pkg::ST_ROW;
            end
         end
         fvn_pkg::ST_DSTART: begin
            div_start = 1'b1;
            state_in  = fvn_pkg::ST_DIV;
         end
         fvn_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = fvn_pkg::ST_OUT;
            end
         end
         fvn_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = fvn_pkg::ST_IDLE;
            end
         end
         default: state_in = fvn_pkg::ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      xw_in       = xw_ff;
      yw_in       = yw_ff;
      oct_cnt_in  = oct_cnt_ff;
      oct_idx_in  = oct_idx_ff;
      p1_in       = p1_ff;
      c00_in      = c00_ff;
      c01_in      = c01_ff;
      lo_prod_in  = lo_prod_ff;
      hi_prod_in  = hi_prod_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      fin_prod_in = fin_prod_ff;
      acc_in      = acc_ff;
      d_corner    = $signed({1'b0, rb_data}) - $signed({1'b0, ra_data});
      blend_sum   = '0;
      d_row       = $signed({1'b0, high_ff}) - $signed({1'b0, low_ff});
      n_sum       = $signed({2'b00, low_ff}) + $signed(fin_prod_ff[41:16]);
      case (state_ff)
         fvn_pkg::ST_IDLE: begin
            // scaled point, two's complement wrap keeps lattice mod T exact
            xw_in      = x_prod[WW-1:0];
            yw_in      = y_prod[WW-1:0];
            oct_cnt_in = oct_clamp;
            oct_idx_in = '0;
            acc_in     = '0;
         end
         fvn_pkg::ST_COL0: begin
            p1_in = rb_data;
         end
         fvn_pkg::ST_COL1: begin
            c00_in     = ra_data;
            lo_prod_in = d_corner * $signed({1'b0, wx});
         end
         fvn_pkg::ST_MIX0: begin
            c01_in     = ra_data;
            hi_prod_in = d_corner * $signed({1'b0, wx});
            blend_sum  = $signed({3'b000, c00_ff, 16'h0000}) + lo_prod_ff;
            low_in     = blend_sum[23:0];
         end
         fvn_pkg::ST_MIX1: begin
            blend_sum = $signed({3'b000, c01_ff, 16'h0000}) + hi_prod_ff;
            high_in   = blend_sum[23:0];
         end
         fvn_pkg::ST_MIX2: begin
            fin_prod_in = d_row * $signed({1'b0, wy});
         end
         fvn_pkg::ST_ACC: begin
            // Horner form of the halving amplitudes
            acc_in     = {acc_ff[AW-2:0], 1'b0} + AW'(n_sum[23:0]);
            xw_in      = {xw_ff[WW-2:0], 1'b0};
            yw_in      = {yw_ff[WW-2:0], 1'b0};
            oct_idx_in = oct_idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fvn_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_data_ff <= quotient;
      end
      xw_ff       <= xw_in;
      yw_ff       <= yw_in;
      oct_cnt_ff  <= oct_cnt_in;
      oct_idx_ff  <= oct_idx_in;
      p1_ff       <= p1_in;
      c00_ff      <= c00_in;
      c01_ff      <= c01_in;
      lo_prod_ff  <= lo_prod_in;
      hi_prod_ff  <= hi_prod_in;
      low_ff      <= low_in;
      high_ff     <= high_in;
      fin_prod_ff <= fin_prod_in;
      acc_ff      <= acc_in;
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.noise_value = rsp_data_ff;

   // table writes never overlap an evaluation's reads
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> state_ff == fvn_pkg::ST_IDLE)
      else $error("table write outside idle");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == fvn_pkg::ST_DIV)
      else $error("divider finished outside its wait state");

   a_octave_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == fvn_pkg::ST_ACC |-> oct_idx_ff < oct_cnt_ff)
      else $error("octave index past octave count");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == fvn_pkg::ST_OUT)
      else $error("result raised outside output state");

endmodule
